// ===== hw/rtl/tvs_pkg.sv =====
// Shared types and constants of the trilinear voxel sampler.
`timescale 1ns / 1ps

package tvs_pkg;

  // Field widths fixed by the interface
  localparam int COORD_W     = 15;
  localparam int IN_SAMPLE_W = 16;
  localparam int STEP_W      = 16;
  localparam int SIZE_W      = 6;
  localparam int GREY_W      = 28;
  localparam int FRAC_BITS   = 12;
  localparam int POS_W       = COORD_W + STEP_W;
  localparam int BASE_W      = POS_W - FRAC_BITS;
  localparam int W_W         = FRAC_BITS + 1;
  localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [W_W-1:0]    ONE_Q12  = W_W'(1 << FRAC_BITS);
  localparam logic [GREY_W-1:0] GREY_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECT = 3'd6;

  // Item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Work kinds passed from front to back
  typedef enum logic [1:0] {
    K_WRITE,
    K_OOR,
    K_DIRECT,
    K_INTERP
  } kind_t;

  typedef struct packed {
    logic                   operation;
    logic [COORD_W-1:0]     coord_x;
    logic [COORD_W-1:0]     coord_y;
    logic [COORD_W-1:0]     coord_z;
    logic [IN_SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [GREY_W-1:0] grey_value;
    logic              out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic [STEP_W-1:0] step_z;
    logic              direct_mode;
  } cfg_t;

endpackage

// ===== hw/rtl/tvs_front.sv =====
// Front end: accepts items, scales coordinates and classifies the work.
`timescale 1ns / 1ps

module tvs_front import tvs_pkg::*; #(
  parameter int AXIS_BITS   = 5,
  parameter int SAMPLE_BITS = 16,
  localparam int ENTRY_W    = 2 + SAMPLE_BITS + 3 * FRAC_BITS + 6 * AXIS_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  input  cfg_t               cfg,
  input  logic               q_full,
  output logic               q_push,
  output logic [ENTRY_W-1:0] q_wdata
);

  localparam int AXIS_LEN = 1 << AXIS_BITS;

  typedef struct packed {
    kind_t                           kind;
    logic [SAMPLE_BITS-1:0]          sample;
    logic [2:0][FRAC_BITS-1:0]       frac;
    logic [2:0][AXIS_BITS-1:0]       up;
    logic [2:0][AXIS_BITS-1:0]       base;
  } entry_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                    state_r, state_nxt;
  in_item_t                   item_r;
  logic [2:0][POS_W-1:0]      pos_r;

  logic [2:0][COORD_W-1:0]    crd;
  logic [2:0][STEP_W-1:0]     stp;
  logic [2:0][SIZE_W-1:0]     sz;
  logic [2:0][AXIS_BITS:0]    n;
  logic [2:0][BASE_W-1:0]     base_full;
  logic [2:0][AXIS_BITS:0]    base_inc;
  logic [2:0]                 in_store, d_oor, i_oor;
  logic                       keep;
  entry_t                     ent;

  // Size 0 acts as 1, sizes past the store act as the store edge
  function automatic logic [AXIS_BITS:0] eff_size(input logic [SIZE_W-1:0] s);
    if (s == '0) begin
      return (AXIS_BITS + 1)'(1);
    end else if (16'(s) > 16'(AXIS_LEN)) begin
      return (AXIS_BITS + 1)'(AXIS_LEN);
    end else begin
      return (AXIS_BITS + 1)'(s);
    end
  endfunction

  assign crd = {item_r.coord_z, item_r.coord_y, item_r.coord_x};
  assign stp = {cfg.step_z, cfg.step_y, cfg.step_x};
  assign sz  = {cfg.size_z, cfg.size_y, cfg.size_x};

  assign in_stall = (state_r != F_IDLE);

  // Per-axis classification
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      n[l]         = eff_size(sz[l]);
      base_full[l] = pos_r[l][POS_W-1:FRAC_BITS];
      in_store[l]  = (crd[l][COORD_W-1:AXIS_BITS] == '0);
      d_oor[l]     = (crd[l] >= COORD_W'(n[l]));
      i_oor[l]     = (base_full[l] >= BASE_W'(n[l]));
      base_inc[l]  = (AXIS_BITS + 1)'(base_full[l][AXIS_BITS-1:0]) + (AXIS_BITS + 1)'(1);
    end
  end

  // Queue entry build
  always_comb begin
    ent        = '0;
    ent.sample = SAMPLE_BITS'(item_r.sample_value);
    keep       = 1'b1;
    for (int l = 0; l < 3; l++) begin
      ent.frac[l] = pos_r[l][FRAC_BITS-1:0];
    end
    if (item_r.operation == OP_WRITE) begin
      ent.kind = K_WRITE;
      keep     = &in_store;
      for (int l = 0; l < 3; l++) begin
        ent.base[l] = crd[l][AXIS_BITS-1:0];
      end
    end else if (cfg.direct_mode) begin
      ent.kind = (|d_oor) ? K_OOR : K_DIRECT;
      for (int l = 0; l < 3; l++) begin
        ent.base[l] = crd[l][AXIS_BITS-1:0];
      end
    end else begin
      ent.kind = (|i_oor) ? K_OOR : K_INTERP;
      for (int l = 0; l < 3; l++) begin
        ent.base[l] = base_full[l][AXIS_BITS-1:0];
        // upper neighbour clamped to the last loaded voxel
        ent.up[l]   = (base_inc[l] < n[l]) ? base_inc[l][AXIS_BITS-1:0]
                                           : AXIS_BITS'(n[l] - (AXIS_BITS + 1)'(1));
      end
    end
  end

  assign q_wdata = ent;
  assign q_push  = (state_r == F_PUSH) && keep && !q_full;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) state_nxt = F_MUL;
      end
      F_MUL: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!keep || !q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item hold and coordinate scaling
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      item_r <= in_item;
    end
    if (state_r == F_MUL) begin
      for (int l = 0; l < 3; l++) begin
        pos_r[l] <= POS_W'(crd[l]) * POS_W'(stp[l]);
      end
    end
  end

endmodule

// ===== hw/rtl/tvs_queue.sv =====
// Short FIFO between the front end and the back end.
`timescale 1ns / 1ps

module tvs_queue #(
  parameter int WIDTH      = 8,
  parameter int DEPTH_BITS = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int DEPTH = 1 << DEPTH_BITS;

  logic [WIDTH-1:0]    slot_r [DEPTH];
  logic [DEPTH_BITS:0] wr_ptr_r, rd_ptr_r;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[DEPTH_BITS] != rd_ptr_r[DEPTH_BITS]) &&
                 (wr_ptr_r[DEPTH_BITS-1:0] == rd_ptr_r[DEPTH_BITS-1:0]);
  assign rdata = slot_r[rd_ptr_r[DEPTH_BITS-1:0]];

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + (DEPTH_BITS + 1)'(1);
      if (pop && !empty) rd_ptr_r <= rd_ptr_r + (DEPTH_BITS + 1)'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wr_ptr_r[DEPTH_BITS-1:0]] <= wdata;
  end

endmodule

// ===== hw/rtl/tvs_back.sv =====
// Back end: voxel memory, corner reads, trilinear blend and result register.
`timescale 1ns / 1ps

module tvs_back import tvs_pkg::*; #(
  parameter int AXIS_BITS   = 5,
  parameter int SAMPLE_BITS = 16,
  localparam int ENTRY_W    = 2 + SAMPLE_BITS + 3 * FRAC_BITS + 6 * AXIS_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  logic [ENTRY_W-1:0] q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item
);

  localparam int ADDR_W      = 3 * AXIS_BITS;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int XP_W        = SAMPLE_BITS + W_W;
  localparam int XL_W        = SAMPLE_BITS + FRAC_BITS;
  localparam int YP_W        = XL_W + W_W;
  localparam int RZ_W        = SAMPLE_BITS + FRAC_BITS;
  localparam int EXT_W       = RZ_W + GREY_W;

  typedef struct packed {
    kind_t                           kind;
    logic [SAMPLE_BITS-1:0]          sample;
    logic [2:0][FRAC_BITS-1:0]       frac;
    logic [2:0][AXIS_BITS-1:0]       up;
    logic [2:0][AXIS_BITS-1:0]       base;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_WAIT = 3'b100
  } bstate_t;

  bstate_t                state_r, state_nxt;
  entry_t                 head, cur_r;
  logic [2:0]             cnt_r;

  logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] mem_q_r;
  logic [ADDR_W-1:0]      mem_addr;
  logic                   mem_we, mem_re;

  // Blend pipeline
  logic                   rd_vld_r, s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic [2:0]             rd_idx_r, s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r, s5_idx_r;
  logic [XP_W-1:0]        px_r, ax_r;
  logic [XL_W-1:0]        xl_r;
  logic [YP_W-1:0]        py_r, ay_r, pz_r, az_r;
  logic [RZ_W-1:0]        rz_r, fin;

  logic                   res_vld_r, res_oor_r;
  logic [GREY_W-1:0]      res_grey_r;
  logic                   out_vld_r;
  out_item_t              out_item_r;

  logic                   head_take, ld_oor, ld_dir, ld_fin, res_move, out_free;

  function automatic logic [W_W-1:0] weight(input logic sel, input logic [FRAC_BITS-1:0] f);
    return sel ? W_W'(f) : ONE_Q12 - W_W'(f);
  endfunction

  function automatic logic [GREY_W-1:0] saturate(input logic [RZ_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    return (ext > EXT_W'(GREY_MAX)) ? GREY_MAX : ext[GREY_W-1:0];
  endfunction

  assign head      = q_rdata;
  assign head_take = (state_r == B_IDLE) && !q_empty;
  assign q_pop     = head_take;

  assign out_free = !out_vld_r || !out_stall;
  assign ld_oor   = head_take && (head.kind == K_OOR);
  assign ld_dir   = rd_vld_r && (cur_r.kind == K_DIRECT);
  assign ld_fin   = s5_vld_r && s5_idx_r[2];
  assign res_move = (state_r == B_WAIT) && res_vld_r && out_free;

  // Single memory port: write from the queue head, or read a corner
  assign mem_we = head_take && (head.kind == K_WRITE);
  assign mem_re = (state_r == B_READ);
  always_comb begin
    if (state_r == B_READ) begin
      mem_addr = {cnt_r[2] ? cur_r.up[2] : cur_r.base[2],
                  cnt_r[1] ? cur_r.up[1] : cur_r.base[1],
                  cnt_r[0] ? cur_r.up[0] : cur_r.base[0]};
    end else begin
      mem_addr = {head.base[2], head.base[1], head.base[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= head.sample;
    if (mem_re) mem_q_r <= mem[mem_addr];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (head_take) begin
          unique case (head.kind) inside
            K_OOR:              state_nxt = B_WAIT;
            K_DIRECT, K_INTERP: state_nxt = B_READ;
            default:            state_nxt = B_IDLE;
          endcase
        end
      end
      B_READ: begin
        if (cur_r.kind == K_DIRECT || cnt_r == 3'd7) state_nxt = B_WAIT;
      end
      B_WAIT: begin
        if (res_move) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      cnt_r     <= '0;
      rd_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= (state_r == B_READ) ? cnt_r + 3'd1 : 3'd0;
      rd_vld_r <= mem_re;
      s1_vld_r <= rd_vld_r && (cur_r.kind == K_INTERP);
      s2_vld_r <= s1_vld_r && s1_idx_r[0];
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r && s3_idx_r[1];
      s5_vld_r <= s4_vld_r;
      if (ld_oor || ld_dir || ld_fin) begin
        res_vld_r <= 1'b1;
      end else if (res_move) begin
        res_vld_r <= 1'b0;
      end
      if (res_move) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Current query
  always_ff @(posedge clk) begin
    if (head_take) cur_r <= head;
  end

  // x, y and z blend stages, one multiply each
  assign fin = RZ_W'((az_r + pz_r + YP_W'(ROUND_HALF)) >> FRAC_BITS);

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    s1_idx_r <= rd_idx_r;
    s2_idx_r <= s1_idx_r;
    s3_idx_r <= s2_idx_r;
    s4_idx_r <= s3_idx_r;
    s5_idx_r <= s4_idx_r;

    px_r <= XP_W'(mem_q_r) * XP_W'(weight(rd_idx_r[0], cur_r.frac[0]));
    if (s1_vld_r && !s1_idx_r[0]) ax_r <= px_r;
    xl_r <= XL_W'(ax_r + px_r);

    py_r <= YP_W'(xl_r) * YP_W'(weight(s2_idx_r[1], cur_r.frac[1]));
    if (s3_vld_r && !s3_idx_r[1]) ay_r <= py_r;
    rz_r <= RZ_W'((ay_r + py_r + YP_W'(ROUND_HALF)) >> FRAC_BITS);

    pz_r <= YP_W'(rz_r) * YP_W'(weight(s4_idx_r[2], cur_r.frac[2]));
    if (s5_vld_r && !s5_idx_r[2]) az_r <= pz_r;
  end

  // Result hold and output register
  always_ff @(posedge clk) begin
    if (ld_oor) begin
      res_grey_r <= '0;
      res_oor_r  <= 1'b1;
    end else if (ld_dir) begin
      res_grey_r <= saturate({mem_q_r, {FRAC_BITS{1'b0}}});
      res_oor_r  <= 1'b0;
    end else if (ld_fin) begin
      res_grey_r <= saturate(fin);
      res_oor_r  <= 1'b0;
    end
    if (res_move) begin
      out_item_r.grey_value   <= res_grey_r;
      out_item_r.out_of_range <= res_oor_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

// ===== hw/rtl/trilinear_voxel_sampler_unit.sv =====
// Top level of the trilinear voxel sampler: configuration registers and block wiring.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | input     | in_valid / in_stall  | in_item: operation, coords, sample
//  out_    | output    | out_valid / out_stall| out_item: grey_value, out_of_range
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  The front end takes one item at a time. In the back end a write goes to memory, an
//  out-of-range query to the result, a direct query reads one voxel, and an interpolated
//  query reads eight corners through the single memory port, then the six-stage blend
//  pipeline drains. A four-entry queue lets the front keep accepting while the back
//  is busy. Reset is synchronous; the voxel memory is not cleared and needs no
//  clearing pass. A stalled result sits in the output register; the back end holds
//  one more.
module trilinear_voxel_sampler_unit import tvs_pkg::*; #(
  parameter int AXIS_BITS   = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ENTRY_W = 2 + SAMPLE_BITS + 3 * FRAC_BITS + 6 * AXIS_BITS;

  cfg_t               cfg_r;
  logic               q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_x      <= SIZE_W'(32);
      cfg_r.size_y      <= SIZE_W'(32);
      cfg_r.size_z      <= SIZE_W'(32);
      cfg_r.step_x      <= STEP_W'(4096);
      cfg_r.step_y      <= STEP_W'(4096);
      cfg_r.step_z      <= STEP_W'(4096);
      cfg_r.direct_mode <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIZE_X: cfg_r.size_x      <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y: cfg_r.size_y      <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z: cfg_r.size_z      <= cfg_data[SIZE_W-1:0];
        REG_STEP_X: cfg_r.step_x      <= cfg_data;
        REG_STEP_Y: cfg_r.step_y      <= cfg_data;
        REG_STEP_Z: cfg_r.step_z      <= cfg_data;
        REG_DIRECT: cfg_r.direct_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tvs_front #(
    .AXIS_BITS   (AXIS_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  tvs_queue #(
    .WIDTH      (ENTRY_W),
    .DEPTH_BITS (2)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tvs_back #(
    .AXIS_BITS   (AXIS_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== hw/rtl/tvs_checker.sv =====
// Port-level checks of the sampler, bound to its top level.
`timescale 1ns / 1ps

module tvs_checker import tvs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // queries accepted whose results are not yet taken
  logic [3:0] pend_r;
  logic       q_acc, r_acc;

  assign q_acc = in_valid && !in_stall && (in_item.operation == OP_QUERY);
  assign r_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(q_acc) - 4'(r_acc);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the front end holds one item at a time
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted back to back");

  // every result answers an earlier query
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without a pending query");

  // out-of-range results carry zero grey
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.out_of_range |-> out_item.grey_value == '0)
    else $error("out-of-range result with nonzero grey");

endmodule

bind trilinear_voxel_sampler_unit tvs_checker u_tvs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== sim/tb_trilinear_voxel_sampler_unit.sv =====
// Self-checking testbench for the trilinear voxel sampler: directed cases, back-pressure, random phases.
`timescale 1ns / 1ps

module tb_trilinear_voxel_sampler_unit;
  import tvs_pkg::*;

  localparam int VOX_AXIS = 32;                            // voxels per axis in the store
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;        // index with no register behind it
  localparam int IDLE_PCT = 37;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 195;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the volume and the registers
  bit [15:0]  vox_mem [0:VOX_AXIS*VOX_AXIS*VOX_AXIS-1];
  bit         vox_known [0:VOX_AXIS*VOX_AXIS*VOX_AXIS-1];
  logic [5:0]  vol_size [3] = '{6'd32, 6'd32, 6'd32};
  logic [15:0] vol_step [3] = '{16'd4096, 16'd4096, 16'd4096};
  bit          vol_direct = 1'b1;

  out_item_t grey_due [$];
  out_item_t grey_want;
  int fails = 0;

  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  int hold_len = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  trilinear_voxel_sampler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Effective voxel count on one axis: 0 reads as 1, anything past the store as the store
  function automatic int unsigned axis_len(input int a);
    if (vol_size[a] == 0) return 1;
    if (vol_size[a] > VOX_AXIS) return VOX_AXIS;
    return vol_size[a];
  endfunction

  // Corner addresses and fractions of a query; corner k has x in bit 0, y in bit 1, z in bit 2
  function automatic void locate_site(input in_item_t it, output bit oor,
                                      output logic [7:0][14:0] addr,
                                      output logic [2:0][11:0] fr);
    int unsigned c [3];
    int unsigned n [3];
    int unsigned lo [3];
    int unsigned hi [3];
    longint unsigned pos;
    c[0] = it.coord_x;
    c[1] = it.coord_y;
    c[2] = it.coord_z;
    oor = 1'b0;
    for (int a = 0; a < 3; a++) begin
      n[a] = axis_len(a);
      fr[a] = '0;
      if (vol_direct) begin
        lo[a] = c[a];
        if (c[a] >= n[a]) oor = 1'b1;
        hi[a] = lo[a];
      end else begin
        pos = c[a];
        pos = pos * vol_step[a];
        lo[a] = pos >> FRAC_BITS;
        fr[a] = pos[11:0];
        // unclamped base past the edge flags the query
        if (lo[a] >= n[a]) begin
          oor = 1'b1;
          lo[a] = 0;
        end
        hi[a] = (lo[a] + 1 < n[a]) ? lo[a] + 1 : n[a] - 1;
      end
    end
    for (int k = 0; k < 8; k++)
      addr[k] = {5'(k[2] ? hi[2] : lo[2]), 5'(k[1] ? hi[1] : lo[1]), 5'(k[0] ? hi[0] : lo[0])};
  endfunction

  // Expected grey value and range flag of one query
  function automatic out_item_t sample_site(input in_item_t it);
    out_item_t r;
    bit oor;
    logic [7:0][14:0] addr;
    logic [2:0][11:0] fr;
    longint unsigned g [8];
    longint unsigned xl [4];
    longint unsigned rz [2];
    longint unsigned fx, fy, fz;
    longint unsigned grey;
    locate_site(it, oor, addr, fr);
    grey = 0;
    if (!oor && vol_direct) begin
      grey = vox_mem[addr[0]];
      grey = grey << FRAC_BITS;
    end else if (!oor) begin
      fx = fr[0];
      fy = fr[1];
      fz = fr[2];
      for (int k = 0; k < 8; k++) g[k] = vox_mem[addr[k]];
      // four x blends, two y blends rounded to Q.12, then z rounded again
      for (int p = 0; p < 4; p++) xl[p] = g[2*p] * (4096 - fx) + g[2*p+1] * fx;
      for (int q = 0; q < 2; q++)
        rz[q] = (xl[2*q] * (4096 - fy) + xl[2*q+1] * fy + ROUND_HALF) >> FRAC_BITS;
      grey = (rz[0] * (4096 - fz) + rz[1] * fz + ROUND_HALF) >> FRAC_BITS;
    end
    if (grey > GREY_MAX) grey = GREY_MAX;
    r.grey_value = oor ? '0 : grey[GREY_W-1:0];
    r.out_of_range = oor;
    return r;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Site coordinate on one axis: mostly inside, sometimes at the edge or anywhere
  function automatic logic [14:0] pick_site(input int a);
    int unsigned n;
    int unsigned t;
    longint unsigned c;
    n = axis_len(a);
    if ($urandom_range(23) == 0) return 15'($urandom);
    t = ($urandom_range(15) == 0) ? n + $urandom_range(1) : $urandom_range(n - 1);
    if (vol_direct) return 15'(t);
    if (vol_step[a] == 0) return 15'($urandom);
    c = t;
    c = (c << FRAC_BITS) + $urandom_range(4095);
    c = c / vol_step[a];
    return (c > 32767) ? 15'h7FFF : 15'(c);
  endfunction

  // Offer one item, with random gaps; valid stays high on return
  task automatic send_item(input in_item_t it);
    while (send_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    if (it.operation == OP_WRITE) begin
      // writes outside the store are dropped
      if (it.coord_x < VOX_AXIS && it.coord_y < VOX_AXIS && it.coord_z < VOX_AXIS) begin
        vox_mem[{it.coord_z[4:0], it.coord_y[4:0], it.coord_x[4:0]}] = it.sample_value;
        vox_known[{it.coord_z[4:0], it.coord_y[4:0], it.coord_x[4:0]}] = 1'b1;
      end
    end else begin
      grey_due.push_back(sample_site(it));
    end
    @(negedge clk);
  endtask

  task automatic send_write(input int x, input int y, input int z, input logic [15:0] s);
    in_item_t it;
    it.operation = OP_WRITE;
    it.coord_x = 15'(x);
    it.coord_y = 15'(y);
    it.coord_z = 15'(z);
    it.sample_value = s;
    send_item(it);
  endtask

  // Query a site; any corner it would read that was never written gets a write first
  task automatic send_query(input int x, input int y, input int z);
    in_item_t it;
    bit oor;
    logic [7:0][14:0] addr;
    logic [2:0][11:0] fr;
    it.operation = OP_QUERY;
    it.coord_x = 15'(x);
    it.coord_y = 15'(y);
    it.coord_z = 15'(z);
    it.sample_value = 16'($urandom);
    locate_site(it, oor, addr, fr);
    if (!oor) begin
      for (int k = 0; k < 8; k++)
        if (!vox_known[addr[k]])
          send_write(addr[k][4:0], addr[k][9:5], addr[k][14:10], pick_sample());
    end
    send_item(it);
  endtask

  // One register write; cfg_valid is left high for the caller
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SIZE_X: vol_size[0] = data[5:0];
      REG_SIZE_Y: vol_size[1] = data[5:0];
      REG_SIZE_Z: vol_size[2] = data[5:0];
      REG_STEP_X: vol_step[0] = data;
      REG_STEP_Y: vol_step[1] = data;
      REG_STEP_Z: vol_step[2] = data;
      REG_DIRECT: vol_direct = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Load every register; unused upper bits carry noise
  task automatic set_config(input logic [5:0] sx, input logic [5:0] sy, input logic [5:0] sz,
                            input logic [15:0] tx, input logic [15:0] ty,
                            input logic [15:0] tz, input bit dm);
    write_reg(REG_SIZE_X, {10'($urandom), sx});
    write_reg(REG_SIZE_Y, {10'($urandom), sy});
    write_reg(REG_SIZE_Z, {10'($urandom), sz});
    write_reg(REG_STEP_X, tx);
    write_reg(REG_STEP_Y, ty);
    write_reg(REG_STEP_Z, tz);
    write_reg(REG_DIRECT, {15'($urandom), dm});
    write_reg(REG_NONE, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, let every due result arrive and any trailing writes retire
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (grey_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Reset registers: direct reads, store edges, dropped writes
  task automatic test_direct_reset();
    send_write(0, 0, 0, 16'h0000);
    send_write(31, 31, 31, 16'hFFFF);
    send_write(31, 0, 0, 16'h1111);
    send_write(32767, 0, 0, 16'h1234);   // past the store, must not alias onto x = 31
    send_write(3, 0, 3, 16'h2222);
    send_write(3, 32, 3, 16'h5A5A);
    send_query(0, 0, 0);
    send_query(31, 31, 31);
    send_query(31, 0, 0);
    send_query(3, 0, 3);
    send_query(32, 0, 0);
    send_query(0, 0, 32767);
    send_query(32767, 32767, 32767);
  endtask

  // Interpolation with half, widest and zero steps, clamped corners and flagged bases
  task automatic test_interp_edges();
    wait_quiet();
    set_config(6'd32, 6'd32, 6'd32, 16'd2048, 16'hFFFF, 16'd0, 1'b0);
    send_query(1, 0, 32767);
    send_query(63, 1, 0);
    send_query(64, 0, 0);
    send_query(0, 33, 0);
  endtask

  // Size of zero, sizes past the store, writes beyond the loaded volume
  task automatic test_size_limits();
    wait_quiet();
    set_config(6'd0, 6'd63, 6'd1, 16'd4096, 16'd4096, 16'd4096, 1'b1);
    send_write(20, 0, 0, 16'h0F0F);
    send_query(0, 31, 0);
    send_query(1, 0, 0);
    send_query(0, 32, 0);
    send_query(0, 0, 1);
  endtask

  // Receiver holds off while queries keep coming, so the block backs up
  task automatic test_input_backpressure();
    wait_quiet();
    set_config(6'd4, 6'd4, 6'd4, 16'd4096, 16'd3000, 16'd4096, 1'b0);
    send_idle_on = 1'b0;
    hold_len = 400;
    hold_req++;
    for (int i = 0; i < 40; i++) send_query(pick_site(0), pick_site(1), pick_site(2));
    send_idle_on = 1'b1;
  endtask

  task automatic random_config();
    logic [5:0] sz [3];
    logic [15:0] st [3];
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(7))
        0: sz[a] = 6'd0;
        1: sz[a] = 6'd32;
        2: sz[a] = 6'($urandom_range(33, 63));
        default: sz[a] = 6'($urandom_range(1, 6));
      endcase
      case ($urandom_range(5))
        0: st[a] = 16'd4096;
        1: st[a] = ($urandom_range(1) == 0) ? 16'd0 : 16'hFFFF;
        2: st[a] = 16'($urandom);
        default: st[a] = 16'($urandom_range(1024, 12288));
      endcase
    end
    set_config(sz[0], sz[1], sz[2], st[0], st[1], st[2], $urandom_range(1));
  endtask

  // Random phases: new registers each time, mostly queries into the loaded volume
  task automatic test_random_phases();
    in_item_t it;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      random_config();
      send_idle_on = (ph != 3);
      recv_idle_on = (ph != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(9) < 3) begin
          it.operation = OP_WRITE;
          it.sample_value = pick_sample();
          case ($urandom_range(9))
            0: begin
              it.coord_x = 15'($urandom);
              it.coord_y = 15'($urandom);
              it.coord_z = 15'($urandom);
            end
            1: begin
              it.coord_x = 15'($urandom_range(VOX_AXIS - 1));
              it.coord_y = 15'($urandom_range(VOX_AXIS - 1));
              it.coord_z = 15'($urandom_range(VOX_AXIS - 1));
            end
            default: begin
              it.coord_x = 15'($urandom_range(axis_len(0) - 1));
              it.coord_y = 15'($urandom_range(axis_len(1) - 1));
              it.coord_z = 15'($urandom_range(axis_len(2) - 1));
            end
          endcase
          send_item(it);
        end else begin
          send_query(pick_site(0), pick_site(1), pick_site(2));
        end
      end
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // Result side stall: long hold on request, else random
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= recv_idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Compare each accepted result with the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (grey_due.size() == 0) begin
        if (fails < 30)
          $display("%0t: unexpected result: expected none, actual grey %0h oor %0b",
                   $time, out_item.grey_value, out_item.out_of_range);
        fails++;
      end else begin
        grey_want = grey_due.pop_front();
        if (out_item.grey_value !== grey_want.grey_value) begin
          if (fails < 30)
            $display("%0t: grey_value mismatch: expected %0h actual %0h",
                     $time, grey_want.grey_value, out_item.grey_value);
          fails++;
        end
        if (out_item.out_of_range !== grey_want.out_of_range) begin
          if (fails < 30)
            $display("%0t: out_of_range mismatch: expected %0b actual %0b",
                     $time, grey_want.out_of_range, out_item.out_of_range);
          fails++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_direct_reset();
    test_interp_edges();
    test_size_limits();
    test_input_backpressure();
    test_random_phases();
    wait_quiet();
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tvs_pkg.sv
hw/rtl/tvs_front.sv
hw/rtl/tvs_queue.sv
hw/rtl/tvs_back.sv
hw/rtl/trilinear_voxel_sampler_unit.sv
hw/rtl/tvs_checker.sv
sim/tb_trilinear_voxel_sampler_unit.sv
